// ----- sv/rnd_pkg.sv -----
// Shared constants and types for the reflected normal-derivative kernel.
// No dependencies.
package rnd_pkg;
  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC = 28;
  localparam int OUT_WIDTH = 48;
  localparam int OUT_FRAC = 32;
  localparam logic [OUT_WIDTH-1:0] OUT_MAX = {1'b0, {(OUT_WIDTH-1){1'b1}}};
  localparam logic [OUT_WIDTH-1:0] OUT_MIN = {1'b1, {(OUT_WIDTH-1){1'b0}}};
  // two root bits per sqrt stage, two quotient bits per divide stage
  localparam int SQRT_STAGES = 18;
  localparam int DIV_STAGES = 24;
  localparam int CORE_STAGES = SQRT_STAGES + DIV_STAGES + 4;
endpackage

// ----- sv/reflected_normal_derivative_kernel.sv -----
// Top level of the reflected normal-derivative kernel.
// Depends on rnd_pkg and rnd_core.
//  channel | ports                      | handshake
//  input   | in_point_*, in_normal_*... | in_valid / in_ready
//  result  | out_kernel_value, singular | out_valid / out_ready
// One word accepted per cycle, back to back, while the output does not stall;
// a word passes 7 front-end stages plus 46 in rnd_core before it leaves.
// Stall freezes the whole pipe; in_ready follows out_ready or an empty output.
// Reset clears stage valid bits only.
module reflected_normal_derivative_kernel #(
  parameter int COORD_WIDTH = rnd_pkg::COORD_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_point_a_x,
  input  logic signed [COORD_WIDTH-1:0] in_point_a_y,
  input  logic signed [COORD_WIDTH-1:0] in_point_a_z,
  input  logic signed [COORD_WIDTH-1:0] in_point_b_x,
  input  logic signed [COORD_WIDTH-1:0] in_point_b_y,
  input  logic signed [COORD_WIDTH-1:0] in_point_b_z,
  input  logic signed [COORD_WIDTH-1:0] in_normal_x,
  input  logic signed [COORD_WIDTH-1:0] in_normal_y,
  input  logic signed [COORD_WIDTH-1:0] in_normal_z,
  input  logic signed [COORD_WIDTH-1:0] in_weight_a,
  input  logic signed [COORD_WIDTH-1:0] in_weight_b,
  input  logic signed [COORD_WIDTH-1:0] in_jacobian_b,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [rnd_pkg::OUT_WIDTH-1:0] out_kernel_value,
  output logic out_singular
);
  import rnd_pkg::*;
  localparam int FRONT_STAGES = 7;
  localparam int NS = FRONT_STAGES + CORE_STAGES;
  typedef logic signed [31:0] q_t;
  logic adv;
  logic [NS-1:0] v_r;
  assign adv = ~v_r[NS-1] | out_ready;
  assign in_ready = adv;
  assign out_valid = v_r[NS-1];
  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (adv) v_r <= {v_r[NS-2:0], in_valid};
  end

  function automatic q_t take(input logic signed [COORD_WIDTH-1:0] w);
    logic signed [COORD_WIDTH+31:0] t;
    t = {{32{w[COORD_WIDTH-1]}}, w};
    if (COORD_WIDTH >= 32) take = q_t'(t >>> (COORD_WIDTH - 32));
    else take = q_t'(t <<< (32 - COORD_WIDTH));
  endfunction

  // stage 1: convert inputs
  q_t a_r [3], b_r [3], n_r [3], wa_r, wb_r, jac_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      a_r[0] <= take(in_point_a_x); a_r[1] <= take(in_point_a_y);
      a_r[2] <= take(in_point_a_z); b_r[0] <= take(in_point_b_x);
      b_r[1] <= take(in_point_b_y); b_r[2] <= take(in_point_b_z);
      n_r[0] <= take(in_normal_x); n_r[1] <= take(in_normal_y);
      n_r[2] <= take(in_normal_z); wa_r <= take(in_weight_a);
      wb_r <= take(in_weight_b); jac_r <= take(in_jacobian_b);
    end
  end
  // stage 2: products
  logic signed [63:0] paa_r [3], pbb_r [3], pab_r [3], pw_r;
  q_t a2_r [3], b2_r [3], n2_r [3], jac2_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        paa_r[i] <= a_r[i] * a_r[i]; pbb_r[i] <= b_r[i] * b_r[i];
        pab_r[i] <= a_r[i] * b_r[i];
      end
      pw_r <= wa_r * wb_r;
      a2_r <= a_r; b2_r <= b_r; n2_r <= n_r; jac2_r <= jac_r;
    end
  end
  // stage 3: dot sums, floored
  logic signed [37:0] na2_r, nb2_r, ab_r;
  logic signed [35:0] w1_r;
  q_t a3_r [3], b3_r [3], n3_r [3], jac3_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      na2_r <= 38'((66'(paa_r[0]) + paa_r[1] + paa_r[2]) >>> FRAC);
      nb2_r <= 38'((66'(pbb_r[0]) + pbb_r[1] + pbb_r[2]) >>> FRAC);
      ab_r  <= 38'((66'(pab_r[0]) + pab_r[1] + pab_r[2]) >>> FRAC);
      w1_r  <= 36'(pw_r >>> FRAC);
      a3_r <= a2_r; b3_r <= b2_r; n3_r <= n2_r; jac3_r <= jac2_r;
    end
  end
  // stage 4: second-level products
  logic signed [75:0] pnn_r;
  logic signed [69:0] pc_r [3];
  logic signed [67:0] pw2_r;
  logic signed [38:0] ab4_r;
  q_t b4_r [3], n4_r [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      pnn_r <= na2_r * nb2_r;
      for (int i = 0; i < 3; i++) pc_r[i] <= nb2_r * a3_r[i];
      pw2_r <= w1_r * jac3_r;
      ab4_r <= 39'(ab_r) <<< 1;
      b4_r <= b3_r; n4_r <= n3_r;
    end
  end
  // stage 5: D, c, W
  logic signed [49:0] d_r;
  logic signed [42:0] c_r [3];
  logic signed [39:0] w_r;
  q_t n5_r [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      d_r <= 50'(51'(1 <<< FRAC) - ab4_r + 51'(pnn_r >>> FRAC));
      for (int i = 0; i < 3; i++) c_r[i] <= 43'(42'(pc_r[i] >>> FRAC) - b4_r[i]);
      w_r <= 40'(pw2_r >>> FRAC);
      n5_r <= n4_r;
    end
  end
  // stage 6: G products
  logic signed [74:0] pg_r [3];
  logic signed [49:0] d6_r;
  logic signed [39:0] w6_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) pg_r[i] <= c_r[i] * n5_r[i];
      d6_r <= d_r; w6_r <= w_r;
    end
  end
  // stage 7: G
  logic signed [49:0] g_r, d7_r;
  logic signed [39:0] w7_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      g_r <= 50'((77'(pg_r[0]) + pg_r[1] + pg_r[2]) >>> FRAC);
      d7_r <= d6_r; w7_r <= w6_r;
    end
  end
  // stages 8..: iterative-unrolled math in sub unit
  rnd_core u_core (
    .clk, .adv, .d_i(d7_r), .g_i(g_r), .w_i(w7_r),
    .kv_o(out_kernel_value), .sing_o(out_singular)
  );

  ap_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kernel_value))
    else $error("output changed under stall");
  ap_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_singular |-> out_kernel_value == '0)
    else $error("singular with nonzero value");
  ap_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready) else $error("pipe blocked while empty");
endmodule

// ----- sv/rnd_core.sv -----
// Back end: sqrt, D^(3/2), |W*G|, division and saturation, pipelined.
// Depends on rnd_pkg; CORE_STAGES (46) register stages, two sqrt or quotient
// bits per stage.
module rnd_core (
  input  logic clk,
  input  logic adv,
  input  logic signed [49:0] d_i,
  input  logic signed [49:0] g_i,
  input  logic signed [39:0] w_i,
  output logic signed [rnd_pkg::OUT_WIDTH-1:0] kv_o,
  output logic sing_o
);
  import rnd_pkg::*;
  localparam int SL = SQRT_STAGES - 1;
  localparam int DL = DIV_STAGES - 1;

  typedef struct packed { logic [39:0] rem; logic [35:0] root; } sq_t;
  typedef struct packed { logic [80:0] rem; logic [47:0] quo; } dv_t;
  typedef struct packed { logic sg; logic neg; } flag_t;

  function automatic sq_t sq_step(sq_t cur, logic [1:0] pair);
    sq_t nxt;
    logic [39:0] sh, trial;
    sh = {cur.rem[37:0], pair};
    trial = {2'b00, cur.root, 2'b01};
    if (sh >= trial) begin
      nxt.rem = sh - trial;
      nxt.root = {cur.root[34:0], 1'b1};
    end else begin
      nxt.rem = sh;
      nxt.root = {cur.root[34:0], 1'b0};
    end
    return nxt;
  endfunction

  // radicand is D*2^28; stage s takes its pairs 35-2s and 34-2s
  function automatic sq_t sq_stage(sq_t cur, logic [43:0] dm, int s);
    logic [71:0] rad;
    rad = {dm, 28'd0};
    return sq_step(sq_step(cur, rad[71-4*s -: 2]), rad[69-4*s -: 2]);
  endfunction

  function automatic dv_t dv_step(dv_t cur, logic [79:0] den, logic nb);
    dv_t nxt;
    logic [80:0] sh;
    sh = {cur.rem[79:0], nb};
    if (sh >= {1'b0, den}) begin
      nxt.rem = sh - {1'b0, den};
      nxt.quo = {cur.quo[46:0], 1'b1};
    end else begin
      nxt.rem = sh;
      nxt.quo = {cur.quo[46:0], 1'b0};
    end
    return nxt;
  endfunction

  // low numerator bits are {m[15:0], 32'd0}; stage t takes bits 47-2t, 46-2t
  function automatic dv_t dv_stage(dv_t cur, logic [79:0] den, logic [15:0] ml, int t);
    logic [47:0] feed;
    feed = {ml, 32'd0};
    return dv_step(dv_step(cur, den, feed[47-2*t]), den, feed[46-2*t]);
  endfunction

  // stage A: magnitudes, |W|*|G| in two partial products
  logic [49:0] gm;
  logic [39:0] wm;
  logic [43:0] dm_a_r;
  logic [60:0] mlo_a_r;
  logic [59:0] mhi_a_r;
  flag_t fl_a_r;
  always_comb begin
    gm = g_i[49] ? 50'(-g_i) : 50'(g_i);
    wm = w_i[39] ? 40'(-w_i) : 40'(w_i);
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      dm_a_r <= (d_i <= 0) ? '0 : d_i[43:0];
      mlo_a_r <= wm[37:0] * gm[22:0];
      mhi_a_r <= wm[37:0] * gm[44:23];
      fl_a_r.sg <= (d_i <= 0);
      fl_a_r.neg <= (w_i < 0) == (g_i < 0);
    end
  end

  // sqrt stages: S = floor(sqrt(D*2^28))
  sq_t sq_s_r [SQRT_STAGES];
  logic [43:0] dm_s_r [SQRT_STAGES];
  logic [82:0] m_s_r [SQRT_STAGES];
  flag_t fl_s_r [SQRT_STAGES];
  always_ff @(posedge clk) begin
    if (adv) begin
      sq_s_r[0] <= sq_stage('0, dm_a_r, 0);
      dm_s_r[0] <= dm_a_r;
      m_s_r[0] <= 83'(mlo_a_r) + {mhi_a_r, 23'd0};
      fl_s_r[0] <= fl_a_r;
      for (int s = 1; s < SQRT_STAGES; s++) begin
        sq_s_r[s] <= sq_stage(sq_s_r[s-1], dm_s_r[s-1], s);
        dm_s_r[s] <= dm_s_r[s-1];
        m_s_r[s] <= m_s_r[s-1];
        fl_s_r[s] <= fl_s_r[s-1];
      end
    end
  end

  // E = D*S in two partial products, then summed
  logic [61:0] elo_r, ehi_r;
  logic [82:0] m_e_r;
  flag_t fl_e_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      elo_r <= dm_s_r[SL] * sq_s_r[SL].root[17:0];
      ehi_r <= dm_s_r[SL] * sq_s_r[SL].root[35:18];
      m_e_r <= m_s_r[SL];
      fl_e_r <= fl_s_r[SL];
    end
  end
  logic [79:0] e_x_r;
  dv_t dvi_r;
  logic [15:0] ml_x_r;
  flag_t fl_x_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      e_x_r <= 80'(elo_r) + {ehi_r, 18'd0};
      dvi_r.rem <= 81'(m_e_r[82:16]);
      dvi_r.quo <= '0;
      ml_x_r <= m_e_r[15:0];
      fl_x_r <= fl_e_r;
    end
  end

  // divide stages: 48 quotient bits of |W*G|*2^32 / E
  dv_t dv_d_r [DIV_STAGES];
  logic [79:0] den_d_r [DIV_STAGES-1];
  logic [15:0] ml_d_r [DIV_STAGES-1];
  logic ovf_d_r [DIV_STAGES];
  flag_t fl_d_r [DIV_STAGES];
  always_ff @(posedge clk) begin
    if (adv) begin
      dv_d_r[0] <= dv_stage(dvi_r, e_x_r, ml_x_r, 0);
      den_d_r[0] <= e_x_r;
      ml_d_r[0] <= ml_x_r;
      ovf_d_r[0] <= dvi_r.rem >= {1'b0, e_x_r};
      fl_d_r[0] <= fl_x_r;
      for (int t = 1; t < DIV_STAGES; t++) begin
        dv_d_r[t] <= dv_stage(dv_d_r[t-1], den_d_r[t-1], ml_d_r[t-1], t);
        ovf_d_r[t] <= ovf_d_r[t-1];
        fl_d_r[t] <= fl_d_r[t-1];
      end
      for (int t = 1; t < DIV_STAGES - 1; t++) begin
        den_d_r[t] <= den_d_r[t-1];
        ml_d_r[t] <= ml_d_r[t-1];
      end
    end
  end

  // saturate
  logic [47:0] q_o, lim, mm;
  always_comb begin
    q_o = dv_d_r[DL].quo;
    lim = fl_d_r[DL].neg ? OUT_MIN : OUT_MAX;
    mm = (ovf_d_r[DL] || q_o > lim) ? lim : q_o;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      kv_o <= fl_d_r[DL].sg ? '0 : (fl_d_r[DL].neg ? -mm : mm);
      sing_o <= fl_d_r[DL].sg;
    end
  end
endmodule
